/* hdl/mood_pkg.sv */
// Shared types and constants of the motion onset/offset detector.
// No dependencies; imported by the sequencer top level and the direction unit.
package mood_pkg;

  // Sequencer states of the top level
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_THR,
    ST_DECIDE,
    ST_DSTART,
    ST_DWAIT,
    ST_LEN,
    ST_RSTART,
    ST_RWAIT,
    ST_OUT
  } mood_state_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MOVE_THR  = 2'd0;
  localparam logic [1:0] CFG_START_CNT = 2'd1;
  localparam logic [1:0] CFG_STOP_CNT  = 2'd2;
  localparam logic [1:0] CFG_GRAVITY   = 2'd3;

  // Register reset values
  localparam logic [15:0] MOVE_THR_RST  = 16'd26;
  localparam logic [7:0]  START_CNT_RST = 8'd20;
  localparam logic [9:0]  STOP_CNT_RST  = 10'd60;
  localparam logic [15:0] GRAVITY_RST   = 16'd2509;

  // Input item kinds
  localparam logic MODE_RESTART = 1'b1;

  // Run counter ceilings
  localparam logic [8:0]  MOVING_RUN_MAX = 9'd511;
  localparam logic [10:0] QUIET_RUN_MAX  = 11'd2047;

  // Direction unit: working width of the signed products, quotient width
  localparam int DIR_W = 70;
  localparam int Q_W   = 15;

endpackage

/* hdl/mood_isqrt.sv */
// Iterative integer square root, one restoring step per cycle.
// Stand-alone; used by the top level for the sample length.
module mood_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] n_in,
  output logic        done,
  output logic [15:0] root,
  output logic [16:0] rem
);

  logic        busy_r;
  logic        done_r;
  logic [3:0]  cnt_r;
  logic [31:0] n_r;
  logic [31:0] r_r;
  logic [31:0] bit_r;
  logic [32:0] trial;

  assign trial = {1'b0, r_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 4'd15;
        n_r    <= n_in;
        r_r    <= '0;
        bit_r  <= 32'h4000_0000;
      end else if (busy_r) begin
        if ({1'b0, n_r} >= trial) begin
          n_r <= n_r - trial[31:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (cnt_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 4'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = r_r[15:0];
  assign rem  = n_r[16:0];

endmodule

/* hdl/mood_dir.sv */
// Iterative rounded unit-vector component: q = round(16384 * a / sqrt(s)).
// Uses mood_pkg; one quotient bit per cycle from incrementally shifted products.
module mood_dir (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [33:0]          s_in,
  input  logic [31:0]          a2_in,
  output logic                 done,
  output logic [mood_pkg::Q_W-1:0] q
);
  import mood_pkg::*;

  // P = (2q-1)^2 * s, mk = (2q-1)*s << (k+2), sk = s << (2k+2)
  logic                    busy_r;
  logic                    done_r;
  logic [3:0]              k_r;
  logic signed [DIR_W-1:0] p_r;
  logic signed [DIR_W-1:0] mk_r;
  logic signed [DIR_W-1:0] sk_r;
  logic signed [DIR_W-1:0] t_r;
  logic [Q_W-1:0]          q_r;
  logic signed [DIR_W-1:0] p_cand;
  logic                    take;
  logic signed [DIR_W-1:0] s_ext;

  assign s_ext  = signed'({{(DIR_W-34){1'b0}}, s_in});
  assign p_cand = p_r + mk_r + sk_r;
  assign take   = (p_cand <= t_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        k_r    <= 4'(Q_W - 1);
        p_r    <= s_ext;
        mk_r   <= -(s_ext <<< 16);
        sk_r   <= s_ext <<< 30;
        t_r    <= signed'({{(DIR_W-62){1'b0}}, a2_in, 30'b0});
        q_r    <= '0;
      end else if (busy_r) begin
        if (take) begin
          p_r      <= p_cand;
          mk_r     <= (mk_r >>> 1) + sk_r;
          q_r[k_r] <= 1'b1;
        end else begin
          mk_r <= mk_r >>> 1;
        end
        sk_r <= sk_r >>> 2;
        if (k_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r - 4'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

/* hdl/motion_onset_offset_detector_top.sv */
// Motion onset/offset detector: sequencer, shared 16x16 multiplier, state.
// Depends on mood_pkg, mood_dir and mood_isqrt.
//
// Each item carries a 3-axis Q8.8 sample (or a restart, mode = 1) and yields
// exactly one result item. The first sample after reset or restart only sets
// the reference. Until motion starts, a sample whose distance from the
// reference exceeds move_threshold replaces the reference and extends the
// moving run; more than start_count such samples in a row mark the onset.
// After onset every sample produces a feature (the sample, its unit
// difference vector in Q1.14 and |length - gravity_level| in Q8.8) until
// more than stop_count quiet samples in a row mark the end; from then on
// results carry motion_finished and no feature. One 16x16 multiplier forms
// all squares under a small sequencer, so the block takes one item at a time.
// Restart, first and post-motion items go straight to the output state; pre-onset
// samples pass the difference, squaring, threshold and decide states; feature
// samples add three 15-step divisions (mood_dir) and a 16-step root (mood_isqrt).
// A finished result sits in the output register, so the next item can be
// accepted while it waits for out_tready.
module motion_onset_offset_detector_top (
  input  logic          clk,
  input  logic          rst_n,
  // configuration write port
  input  logic          cfg_we,
  input  logic [1:0]    cfg_addr,
  input  logic [15:0]   cfg_wdata,
  // input channel
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [47:0]   in_tdata,   // accel_x, accel_y, accel_z
  input  logic          in_tuser,   // mode
  // result channel
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [111:0]  out_tdata,  // sample_x/y/z, direction_x/y/z, gravity_deviation
  output logic [1:0]    out_tuser   // feature_valid, motion_finished
);
  import mood_pkg::*;

  // configuration
  logic [15:0] move_thr_r;
  logic [7:0]  start_cnt_r;
  logic [9:0]  stop_cnt_r;
  logic [15:0] gravity_r;

  // detector state
  logic              have_ref_r;
  logic              started_r;
  logic              stopped_r;
  logic signed [15:0] ref_r [3];
  logic [8:0]        moving_r;
  logic [10:0]       quiet_r;

  // per-item working registers
  mood_state_t       state_r, state_nxt;
  logic signed [15:0] cur_r [3];
  logic [15:0]       a_r [3];
  logic              neg_r [3];
  logic [31:0]       sq_r [3];
  logic [33:0]       acc_r;
  logic [31:0]       thr2_r;
  logic [1:0]        idx_r;

  // result staging
  logic              res_feat_r;
  logic              res_fin_r;
  logic [15:0]       res_smp_r [3];
  logic [15:0]       res_dir_r [3];
  logic [15:0]       res_dev_r;

  // output register
  logic              out_valid_r;
  logic [111:0]      out_data_r;
  logic [1:0]        out_user_r;

  // control
  logic              accept;
  logic              dir_start, dir_done;
  logic [Q_W-1:0]    dir_q;
  logic              rt_start, rt_done;
  logic [15:0]       rt_root;
  logic [16:0]       rt_rem;
  logic              load_out;
  logic [15:0]       mul_a;
  logic [31:0]       prod;
  logic [15:0]       abs_cur;
  logic [8:0]        moving_inc;
  logic [10:0]       quiet_inc;
  logic              is_gt, is_lt;
  logic [16:0]       len;
  logic [16:0]       dev;
  logic [16:0]       diff [3];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // magnitude of the current sample axis under the index
  assign abs_cur = cur_r[idx_r][15] ? 16'(-cur_r[idx_r]) : cur_r[idx_r];

  // shared multiplier: squares of differences, of the threshold, of sample axes
  always_comb begin
    unique case (state_r)
      ST_SQ:   mul_a = a_r[idx_r];
      ST_THR:  mul_a = move_thr_r;
      ST_LEN:  mul_a = abs_cur;
      default: mul_a = a_r[idx_r];
    endcase
  end
  assign prod = mul_a * mul_a;

  for (genvar g = 0; g < 3; g++) begin : g_diff
    assign diff[g] = {cur_r[g][15], cur_r[g]} - {ref_r[g][15], ref_r[g]};
  end

  assign is_gt      = acc_r > {2'b0, thr2_r};
  assign is_lt      = acc_r < {2'b0, thr2_r};
  assign moving_inc = (moving_r == MOVING_RUN_MAX) ? moving_r : moving_r + 9'd1;
  assign quiet_inc  = (quiet_r == QUIET_RUN_MAX) ? quiet_r : quiet_r + 11'd1;

  // round the length to nearest; the deviation stays below 65536
  assign len = (rt_rem > {1'b0, rt_root}) ? {1'b0, rt_root} + 17'd1 : {1'b0, rt_root};
  assign dev = (len > {1'b0, gravity_r}) ? len - {1'b0, gravity_r}
                                         : {1'b0, gravity_r} - len;

  // next state and strobes
  always_comb begin
    state_nxt = state_r;
    dir_start = 1'b0;
    rt_start  = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser == MODE_RESTART || !have_ref_r || stopped_r) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_DIFF;
          end
        end
      end
      ST_DIFF: state_nxt = ST_SQ;
      ST_SQ: begin
        if (idx_r == 2'd2) state_nxt = ST_THR;
      end
      ST_THR: state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!started_r) state_nxt = ST_OUT;
        else if (acc_r != '0) state_nxt = ST_DSTART;
        else state_nxt = ST_LEN;
      end
      ST_DSTART: begin
        dir_start = 1'b1;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (dir_done) state_nxt = (idx_r == 2'd2) ? ST_LEN : ST_DSTART;
      end
      ST_LEN: begin
        if (idx_r == 2'd2) state_nxt = ST_RSTART;
      end
      ST_RSTART: begin
        rt_start  = 1'b1;
        state_nxt = ST_RWAIT;
      end
      ST_RWAIT: begin
        if (rt_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_thr_r  <= MOVE_THR_RST;
      start_cnt_r <= START_CNT_RST;
      stop_cnt_r  <= STOP_CNT_RST;
      gravity_r   <= GRAVITY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MOVE_THR:  move_thr_r  <= cfg_wdata;
        CFG_START_CNT: start_cnt_r <= cfg_wdata[7:0];
        CFG_STOP_CNT:  stop_cnt_r  <= cfg_wdata[9:0];
        CFG_GRAVITY:   gravity_r   <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // detector state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_ref_r <= 1'b0;
      started_r  <= 1'b0;
      stopped_r  <= 1'b0;
      moving_r   <= '0;
      quiet_r    <= '0;
      for (int i = 0; i < 3; i++) ref_r[i] <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            if (in_tuser == MODE_RESTART) begin
              // clear everything; registers keep their values
              have_ref_r <= 1'b0;
              started_r  <= 1'b0;
              stopped_r  <= 1'b0;
              moving_r   <= '0;
              quiet_r    <= '0;
              for (int i = 0; i < 3; i++) ref_r[i] <= '0;
            end else if (!have_ref_r) begin
              have_ref_r <= 1'b1;
              for (int i = 0; i < 3; i++) ref_r[i] <= in_tdata[16*i +: 16];
            end
          end
        end
        ST_DECIDE: begin
          if (!started_r) begin
            if (is_gt) begin
              moving_r <= moving_inc;
              for (int i = 0; i < 3; i++) ref_r[i] <= cur_r[i];
              if (moving_inc > {1'b0, start_cnt_r}) started_r <= 1'b1;
            end else begin
              moving_r <= '0;
            end
          end else begin
            if (is_lt) begin
              quiet_r <= quiet_inc;
              if (quiet_inc > {1'b0, stop_cnt_r}) stopped_r <= 1'b1;
            end else begin
              quiet_r <= '0;
            end
            for (int i = 0; i < 3; i++) ref_r[i] <= cur_r[i];
          end
        end
        default: ;
      endcase
    end
  end

  // working datapath and result staging
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          for (int i = 0; i < 3; i++) begin
            cur_r[i]     <= in_tdata[16*i +: 16];
            res_smp_r[i] <= '0;
            res_dir_r[i] <= '0;
          end
          res_feat_r <= 1'b0;
          res_dev_r  <= '0;
          // only a sample after the end of motion reports it without a feature
          res_fin_r  <= (in_tuser != MODE_RESTART) && have_ref_r && stopped_r;
        end
      end
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          neg_r[i] <= diff[i][16];
          a_r[i]   <= diff[i][16] ? 16'(-diff[i]) : diff[i][15:0];
        end
        acc_r <= '0;
        idx_r <= 2'd0;
      end
      ST_SQ: begin
        sq_r[idx_r] <= prod;
        acc_r       <= acc_r + {2'b0, prod};
        idx_r       <= idx_r + 2'd1;
      end
      ST_THR: thr2_r <= prod;
      ST_DECIDE: begin
        idx_r <= 2'd0;
        if (started_r) begin
          res_feat_r <= 1'b1;
          res_fin_r  <= stopped_r || (is_lt && (quiet_inc > {1'b0, stop_cnt_r}));
          for (int i = 0; i < 3; i++) res_smp_r[i] <= cur_r[i];
        end
      end
      ST_DWAIT: begin
        if (dir_done) begin
          // apply the sign of the difference
          res_dir_r[idx_r] <= neg_r[idx_r] ? 16'(-{1'b0, dir_q}) : {1'b0, dir_q};
          if (idx_r == 2'd2) begin
            idx_r <= 2'd0;
            acc_r <= '0;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
      end
      ST_LEN: begin
        acc_r <= acc_r + {2'b0, prod};
        idx_r <= idx_r + 2'd1;
      end
      ST_RWAIT: begin
        if (rt_done) res_dev_r <= dev[15:0];
      end
      default: ;
    endcase
  end

  // output register: hold until taken, load on a free slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= {res_dev_r, res_dir_r[2], res_dir_r[1], res_dir_r[0],
                     res_smp_r[2], res_smp_r[1], res_smp_r[0]};
      out_user_r <= {res_fin_r, res_feat_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  mood_dir u_dir (
    .clk   (clk),
    .rst_n (rst_n),
    .start (dir_start),
    .s_in  (acc_r),
    .a2_in (sq_r[idx_r]),
    .done  (dir_done),
    .q     (dir_q)
  );

  mood_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (rt_start),
    .n_in  (acc_r[31:0]),
    .done  (rt_done),
    .root  (rt_root),
    .rem   (rt_rem)
  );

endmodule
